### design/pkgate_pkg.sv
`default_nettype none

package pkgate_pkg;

  localparam int PortW   = 16;
  localparam int TimeW   = 32;
  localparam int CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FIRST_KNOCK  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SECOND_KNOCK = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THIRD_KNOCK  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PROTECTED    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_GAP      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_AGE      = 3'd5;

  // header commands
  localparam logic CMD_INBOUND  = 1'b0;
  localparam logic CMD_OUTBOUND = 1'b1;

  localparam logic [PortW-1:0] RST_FIRST_KNOCK  = 16'd14234;
  localparam logic [PortW-1:0] RST_SECOND_KNOCK = 16'd9786;
  localparam logic [PortW-1:0] RST_THIRD_KNOCK  = 16'd32232;
  localparam logic [PortW-1:0] RST_PROTECTED    = 16'd111;
  localparam logic [PortW-1:0] RST_MAX_GAP      = 16'd3;
  localparam logic [PortW-1:0] RST_MAX_AGE      = 16'd5;

  localparam logic [TimeW-1:0] RST_TIME0 = 32'd0;
  localparam logic [TimeW-1:0] RST_TIME1 = 32'd10;
  localparam logic [TimeW-1:0] RST_TIME2 = 32'd20;

  typedef struct packed {
    logic hide_ok;   // knock valid as seen by a protected-port header
    logic third_ok;  // knock valid once the third slot takes now
  } knock_chk_t;

  // signed 32-bit difference <= unsigned 16-bit limit
  function automatic logic diff_le(input logic [TimeW-1:0] d, input logic [PortW-1:0] m);
    diff_le = d[TimeW-1] | ((d[TimeW-2:PortW] == '0) && (d[PortW-1:0] <= m));
  endfunction

endpackage

`default_nettype wire

### design/port_knock_gate_unit.sv
`default_nettype none

// channel | handshake          | word
// --------+--------------------+-------------------------------------------------
// in      | in_valid/in_stall  | cmd, is_udp, dest_port, source_port, now_seconds
// out     | out_valid/out_stall| force_reset, hidden_now
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (16 bits), ready always high
//
// One word per cycle unless out_stall holds; stages: input register, result register.
// Knock times and hidden flag update at the edge the word moves into the result register.
// rst_n (synchronous) restores register defaults, knock times 0/10/20, port not hidden.
// A stalled output keeps the input register loaded; in_stall rises once both are full.

module port_knock_gate_unit
  import pkgate_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic               in_is_udp,
  input  wire logic [PortW-1:0]   in_dest_port,
  input  wire logic [PortW-1:0]   in_source_port,
  input  wire logic [TimeW-1:0]   in_now_seconds,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_force_reset,
  output logic                    out_hidden_now,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [PortW-1:0]   cfg_data
);

  logic [PortW-1:0] first_knock_r, second_knock_r, third_knock_r;
  logic [PortW-1:0] protected_r, max_gap_r, max_age_r;

  logic [TimeW-1:0] time0_r, time1_r, time2_r;
  logic [TimeW-1:0] time0_nxt, time1_nxt, time2_nxt;
  logic             hidden_r, hidden_nxt;

  logic             s1_valid_r;
  logic             s1_cmd_r, s1_udp_r;
  logic [PortW-1:0] s1_dport_r, s1_sport_r;
  logic [TimeW-1:0] s1_now_r;

  logic             out_valid_r, out_force_r, out_hidden_r;
  logic             force_nxt;

  logic             advance, fire, take;
  logic             inbound, hide_hit, k0, k1, k2;
  knock_chk_t       chk;

  assign cfg_ready = 1'b1;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  pkgate_check u_check (
    .time0       (time0_r),
    .time1       (time1_r),
    .time2       (time2_r),
    .now_seconds (s1_now_r),
    .max_gap     (max_gap_r),
    .max_age     (max_age_r),
    .chk         (chk)
  );

  always_comb begin
    inbound  = !s1_udp_r && (s1_cmd_r == CMD_INBOUND);
    hide_hit = inbound && (s1_dport_r == protected_r) && !hidden_r && !chk.hide_ok;
    // first matching knock slot wins
    k0 = inbound && !hide_hit && (s1_dport_r == first_knock_r);
    k1 = inbound && !hide_hit && !k0 && (s1_dport_r == second_knock_r);
    k2 = inbound && !hide_hit && !k0 && !k1 && (s1_dport_r == third_knock_r);

    time0_nxt  = k0 ? s1_now_r : time0_r;
    time1_nxt  = k1 ? s1_now_r : time1_r;
    time2_nxt  = k2 ? s1_now_r : time2_r;
    hidden_nxt = hidden_r;
    if (hide_hit) begin
      hidden_nxt = 1'b1;
    end else if (k2 && chk.third_ok) begin
      hidden_nxt = 1'b0;
    end
    force_nxt = !s1_udp_r && (s1_cmd_r == CMD_OUTBOUND) &&
                (s1_sport_r == protected_r) && hidden_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_knock_r  <= RST_FIRST_KNOCK;
      second_knock_r <= RST_SECOND_KNOCK;
      third_knock_r  <= RST_THIRD_KNOCK;
      protected_r    <= RST_PROTECTED;
      max_gap_r      <= RST_MAX_GAP;
      max_age_r      <= RST_MAX_AGE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIRST_KNOCK:  first_knock_r  <= cfg_data;
        REG_SECOND_KNOCK: second_knock_r <= cfg_data;
        REG_THIRD_KNOCK:  third_knock_r  <= cfg_data;
        REG_PROTECTED:    protected_r    <= cfg_data;
        REG_MAX_GAP:      max_gap_r      <= cfg_data;
        REG_MAX_AGE:      max_age_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time0_r     <= RST_TIME0;
      time1_r     <= RST_TIME1;
      time2_r     <= RST_TIME2;
      hidden_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        time0_r  <= time0_nxt;
        time1_r  <= time1_nxt;
        time2_r  <= time2_nxt;
        hidden_r <= hidden_nxt;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd_r   <= in_cmd;
      s1_udp_r   <= in_is_udp;
      s1_dport_r <= in_dest_port;
      s1_sport_r <= in_source_port;
      s1_now_r   <= in_now_seconds;
    end
    if (fire) begin
      out_force_r  <= force_nxt;
      out_hidden_r <= hidden_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_force_reset = out_force_r;
  assign out_hidden_now  = out_hidden_r;

  // an outbound rewrite only happens while hidden, and does not change the flag
  a_force_implies_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_force_r |-> out_hidden_r)
    else $error("force_reset without hidden flag");

  a_hidden_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(hidden_r))
    else $error("hidden flag changed without a word");

  a_times_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(time0_r) && $stable(time1_r) && $stable(time2_r))
    else $error("knock time changed without a word");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && (out_hidden_r == hidden_r))
    else $error("result hidden flag differs from state");

endmodule

`default_nettype wire

### design/pkgate_check.sv
`default_nettype none

module pkgate_check
  import pkgate_pkg::*;
(
  input  wire logic [TimeW-1:0] time0,
  input  wire logic [TimeW-1:0] time1,
  input  wire logic [TimeW-1:0] time2,
  input  wire logic [TimeW-1:0] now_seconds,
  input  wire logic [PortW-1:0] max_gap,
  input  wire logic [PortW-1:0] max_age,
  output knock_chk_t            chk
);

  logic [TimeW-1:0] d0, d1, age, d1_new;

  assign d0     = time1 - time0;
  assign d1     = time2 - time1;
  assign age    = now_seconds - time2;
  assign d1_new = now_seconds - time1;  // gap if slot 2 is overwritten by now

  // after a third knock the age is zero, which always passes
  assign chk.hide_ok  = diff_le(age, max_age) & diff_le(d0, max_gap) & diff_le(d1, max_gap);
  assign chk.third_ok = diff_le(d0, max_gap) & diff_le(d1_new, max_gap);

endmodule

`default_nettype wire
